/* src/ngf_pkg.sv */
// Shared types and constants for the pairwise gravity force core.
// Used by ngf_alu and the top level; depends on nothing.
package ngf_pkg;

  localparam int unsigned ALU_W    = 128;  // operand and result width of the shared unit
  localparam int unsigned DEN_W    = 67;   // divisor / second operand width
  localparam int unsigned MUL_BITS = 34;   // multiplier bits consumed by a multiply
  localparam int unsigned DIV_BITS = 128;  // quotient bits produced by a divide
  localparam int unsigned SQ_BITS  = 33;   // root bits produced by a square root
  localparam int unsigned CNT_W    = 8;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

endpackage

/* src/ngf_alu.sv */
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide,
// digit-by-digit square root. Depends on ngf_pkg.
module ngf_alu import ngf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  alu_req_t            req,
  input  logic [ALU_W-1:0]    opa,
  input  logic [DEN_W-1:0]    opb,
  output logic                busy,
  output logic                done,
  output logic [ALU_W-1:0]    result
);

  alu_op_t            op;
  logic [ALU_W-1:0]   x;
  logic [ALU_W-1:0]   acc;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W-1:0]   y;
  logic [CNT_W-1:0]   cnt;

  logic [DEN_W-1:0]   div_sh;
  logic               div_ge;
  logic [DEN_W-1:0]   sq_sh;
  logic [DEN_W-1:0]   sq_trial;
  logic               sq_ge;

  assign div_sh   = {rem[DEN_W-2:0], x[ALU_W-1]};
  assign div_ge   = div_sh >= y;
  assign sq_sh    = {rem[DEN_W-3:0], x[ALU_W-1:ALU_W-2]};
  assign sq_trial = {acc[DEN_W-3:0], 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  always_comb begin
    unique case (op)
      ALU_DIV: result = x;
      default: result = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        op   <= req.op;
        rem  <= '0;
        acc  <= '0;
        y    <= opb;
        unique case (req.op)
          ALU_MUL: begin
            x   <= opa;
            cnt <= CNT_W'(MUL_BITS);
          end
          ALU_DIV: begin
            x   <= opa;
            cnt <= CNT_W'(DIV_BITS);
          end
          default: begin
            // align the 66-bit radicand to the top of the shifter
            x   <= {opa[2*SQ_BITS-1:0], {(ALU_W-2*SQ_BITS){1'b0}}};
            cnt <= CNT_W'(SQ_BITS);
          end
        endcase
      end else if (busy) begin
        unique case (op)
          ALU_MUL: begin
            if (y[0]) acc <= acc + x;
            x <= {x[ALU_W-2:0], 1'b0};
            y <= {1'b0, y[DEN_W-1:1]};
          end
          ALU_DIV: begin
            rem <= div_ge ? div_sh - y : div_sh;
            x   <= {x[ALU_W-2:0], div_ge};
          end
          default: begin
            rem <= sq_ge ? sq_sh - sq_trial : sq_sh;
            acc <= {acc[ALU_W-2:0], sq_ge};
            x   <= {x[ALU_W-3:0], 2'b00};
          end
        endcase
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while still busy");
  a_start_once: assert property (@(posedge clk) disable iff (rst)
    (req.start && !busy) |=> busy)
    else $error("start not taken");
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("busy with empty step count");

endmodule

/* src/nbody_pairwise_gravity_force_core.sv */
// Top level of the all-pairs 2D gravity force core: body store, force
// accumulators and pass sequencer. Depends on ngf_pkg and ngf_alu.
//
// Usage
//   Input channel (in_valid/in_ready): one word per body - position, mass,
//   radius, active flag. A word with last_body set closes the set and starts
//   the pass. Words beyond MAX_BODIES are dropped, but a last_body mark on
//   one is still obeyed. in_ready is high only while the core is idle.
//   Output channel (out_valid/out_ready): one word per loaded body, in load
//   order, with body_index, last_force on the final one and saturated when
//   any pair force or accumulation of that body clipped. Inactive bodies
//   report zero force. While the receiver stalls the word is held.
//   Configuration: cfg_wr_en writes cfg_wr_data to G (Q16.16) at once;
//   write it only while idle.
// Pass sequence
//   Loading accepts one word per cycle. A pass clears N accumulator entries,
//   then visits N*(N-1)/2 pairs. Each pair of active bodies runs 10 serial
//   operations on the one shared unit (13 when inside the earlier body's
//   radius): bit-serial multiplies, a square root and restoring divides,
//   each handed off and awaited in turn; a coincident pair stops after the
//   two squares and an inactive pair skips the shared unit. Each output word
//   is read from the accumulator store before it is shown.
// Reset
//   Clears the sequencer and load count and sets G to 1.0. The body and
//   accumulator memories are not cleared; a pass only reads what it wrote.
module nbody_pairwise_gravity_force_core import ngf_pkg::*; #(
  parameter int unsigned MAX_BODIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic [31:0]         body_mass,
  input  logic [31:0]         body_radius,
  input  logic                body_active,
  input  logic                last_body,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [47:0]  force_x,
  output logic signed [47:0]  force_y,
  output logic [5:0]          body_index,
  output logic                last_force,
  output logic                saturated
);

  localparam int unsigned IW = $clog2(MAX_BODIES);
  localparam int unsigned CW = $clog2(MAX_BODIES + 1);
  localparam logic [47:0] FMAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] FMIN = {1'b1, {47{1'b0}}};
  localparam logic [80:0] CAP80 = {1'b1, 80'b0};

  typedef struct packed {
    logic        active;
    logic [31:0] radius;
    logic [31:0] mass;
    logic [31:0] py;
    logic [31:0] px;
  } body_t;

  typedef struct packed {
    logic        sat;
    logic [47:0] fy;
    logic [47:0] fx;
  } accum_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_RD_I, S_RD_J, S_CAP_J, S_CALC,
    S_ACC_I, S_ACC_J, S_ACC_W, S_NEXT, S_OUT_RD, S_OUT_SHOW
  } state_t;

  typedef enum logic [3:0] {
    P_SQX, P_SQY, P_SQRT, P_GM, P_PM, P_RR, P_DT, P_TD, P_DR, P_DS,
    P_MX, P_DX, P_MY, P_DY
  } step_t;

  function automatic logic [48:0] sat_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) return {1'b1, s[48] ? FMIN : FMAX};
    return {1'b0, s[47:0]};
  endfunction

  state_t          state;
  step_t           step;
  logic            wait_alu;
  logic [31:0]     grav;
  logic [CW-1:0]   count;
  logic [CW-1:0]   n;
  logic [CW-1:0]   i;
  logic [CW-1:0]   j;
  logic [CW-1:0]   k;

  body_t           body_mem [MAX_BODIES];
  body_t           body_rd;
  logic [IW-1:0]   body_raddr;
  accum_t          acc_mem [MAX_BODIES];
  accum_t          acc_rd;
  logic [IW-1:0]   acc_raddr;
  logic            acc_we;
  logic [IW-1:0]   acc_waddr;
  accum_t          acc_wdata;

  body_t           bi;
  body_t           bj;
  logic [32:0]     ax;
  logic [32:0]     ay;
  logic            sgx;
  logic            sgy;
  logic [65:0]     s;
  logic [33:0]     d;
  logic [95:0]     p;
  logic [127:0]    num;
  logic [80:0]     mag;
  logic [46:0]     fxm;
  logic [46:0]     fym;
  logic            psat;

  alu_req_t        alu_req;
  logic [ALU_W-1:0] alu_a;
  logic [DEN_W-1:0] alu_b;
  logic            alu_busy;
  logic            alu_done;
  logic [ALU_W-1:0] alu_res;

  logic signed [32:0] dx_w;
  logic signed [32:0] dy_w;
  logic [65:0]     s_sum;
  logic [80:0]     res_clamp;
  logic            res_big;
  logic [46:0]     res_comp;
  logic [47:0]     fx_s;
  logic [47:0]     fy_s;
  logic [48:0]     sum_x;
  logic [48:0]     sum_y;
  logic            load_ok;

  ngf_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .opa    (alu_a),
    .opb    (alu_b),
    .busy   (alu_busy),
    .done   (alu_done),
    .result (alu_res)
  );

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && load_ok) begin
      body_mem[count[IW-1:0]] <= '{active: body_active, radius: body_radius,
                                   mass: body_mass, py: pos_y, px: pos_x};
    end
    body_rd <= body_mem[body_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rd <= acc_mem[acc_raddr];
  end

  assign load_ok   = count < CW'(MAX_BODIES);
  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT_SHOW;
  assign force_x   = acc_rd.fx;
  assign force_y   = acc_rd.fy;
  assign saturated = acc_rd.sat;
  assign body_index = 6'(k[IW-1:0]);
  assign last_force = k == n - 1'b1;

  // pair geometry from body i (held) and body j (just read)
  assign dx_w = $signed({body_rd.px[31], body_rd.px}) - $signed({bi.px[31], bi.px});
  assign dy_w = $signed({body_rd.py[31], body_rd.py}) - $signed({bi.py[31], bi.py});

  assign s_sum     = s + alu_res[65:0];
  assign res_big   = alu_res[127:80] != '0;
  assign res_clamp = res_big ? CAP80 : alu_res[80:0];
  assign res_comp  = (alu_res[127:47] != '0) ? {47{1'b1}} : alu_res[46:0];

  assign fx_s  = sgx ? -{1'b0, fxm} : {1'b0, fxm};
  assign fy_s  = sgy ? -{1'b0, fym} : {1'b0, fym};
  assign sum_x = sat_add(acc_rd.fx, (state == S_ACC_J) ? fx_s : -fx_s);
  assign sum_y = sat_add(acc_rd.fy, (state == S_ACC_J) ? fy_s : -fy_s);

  always_comb begin
    body_raddr = i[IW-1:0];
    if (state == S_RD_J) body_raddr = j[IW-1:0];
  end

  always_comb begin
    acc_raddr = k[IW-1:0];
    acc_we    = 1'b0;
    acc_waddr = k[IW-1:0];
    acc_wdata = '0;
    unique case (state)
      S_CLR: acc_we = 1'b1;
      S_ACC_I: acc_raddr = i[IW-1:0];
      S_ACC_J: begin
        acc_raddr = j[IW-1:0];
        acc_we    = 1'b1;
        acc_waddr = i[IW-1:0];
        acc_wdata = '{sat: acc_rd.sat | psat | sum_x[48] | sum_y[48],
                      fy: sum_y[47:0], fx: sum_x[47:0]};
      end
      S_ACC_W: begin
        acc_raddr = j[IW-1:0];
        acc_we    = 1'b1;
        acc_waddr = j[IW-1:0];
        acc_wdata = '{sat: acc_rd.sat | psat | sum_x[48] | sum_y[48],
                      fy: sum_y[47:0], fx: sum_x[47:0]};
      end
      default: ;
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    alu_req.start = (state == S_CALC) && !wait_alu;
    alu_req.op    = ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    unique case (step)
      P_SQX: begin alu_a = ALU_W'(ax); alu_b = DEN_W'(ax); end
      P_SQY: begin alu_a = ALU_W'(ay); alu_b = DEN_W'(ay); end
      P_SQRT: begin alu_req.op = ALU_SQRT; alu_a = ALU_W'(s); end
      P_GM: begin alu_a = ALU_W'(grav); alu_b = DEN_W'(bi.mass); end
      P_PM: begin alu_a = ALU_W'(p); alu_b = DEN_W'(bj.mass); end
      P_RR: begin alu_a = ALU_W'(bj.radius); alu_b = DEN_W'(bj.radius); end
      P_DT: begin alu_req.op = ALU_DIV; alu_a = ALU_W'(p); alu_b = num[DEN_W-1:0]; end
      P_TD: begin alu_a = ALU_W'(mag); alu_b = DEN_W'(d); end
      P_DR: begin alu_req.op = ALU_DIV; alu_a = num; alu_b = DEN_W'(bj.radius); end
      P_DS: begin alu_req.op = ALU_DIV; alu_a = ALU_W'(p); alu_b = DEN_W'(s); end
      P_MX: begin alu_a = ALU_W'(mag); alu_b = DEN_W'(ax); end
      P_DX: begin alu_req.op = ALU_DIV; alu_a = num; alu_b = DEN_W'(d); end
      P_MY: begin alu_a = ALU_W'(mag); alu_b = DEN_W'(ay); end
      P_DY: begin alu_req.op = ALU_DIV; alu_a = num; alu_b = DEN_W'(d); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= P_SQX;
      wait_alu <= 1'b0;
      grav     <= 32'h0001_0000;
      count    <= '0;
      n        <= '0;
      i        <= '0;
      j        <= '0;
      k        <= '0;
    end else begin
      if (cfg_wr_en) grav <= cfg_wr_data;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (load_ok) count <= count + 1'b1;
            if (last_body) begin
              n     <= load_ok ? count + 1'b1 : count;
              k     <= '0;
              state <= S_CLR;
            end
          end
        end
        S_CLR: begin
          // wipe one accumulator entry a cycle
          if (k == n - 1'b1) begin
            k <= '0;
            i <= CW'(1);
            j <= '0;
            state <= (n == CW'(1)) ? S_OUT_RD : S_RD_I;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_RD_I: state <= S_RD_J;
        S_RD_J: begin
          bi    <= body_rd;
          state <= S_CAP_J;
        end
        S_CAP_J: begin
          bj   <= body_rd;
          ax   <= dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
          ay   <= dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
          sgx  <= dx_w[32];
          sgy  <= dy_w[32];
          psat <= 1'b0;
          step <= P_SQX;
          state <= (bi.active && body_rd.active) ? S_CALC : S_NEXT;
        end
        S_CALC: begin
          if (!wait_alu) begin
            wait_alu <= 1'b1;
          end else if (alu_done) begin
            wait_alu <= 1'b0;
            unique case (step)
              P_SQX: begin s <= alu_res[65:0]; step <= P_SQY; end
              P_SQY: begin
                s <= s_sum;
                // coincident bodies add nothing
                if (s_sum == '0) state <= S_NEXT;
                else step <= P_SQRT;
              end
              P_SQRT: begin d <= alu_res[33:0]; step <= P_GM; end
              P_GM: begin p <= alu_res[95:0]; step <= P_PM; end
              P_PM: begin
                p    <= alu_res[95:0];
                step <= ({2'b00, bj.radius} > d) ? P_RR : P_DS;
              end
              P_RR: begin num <= alu_res; step <= P_DT; end
              P_DT: begin mag <= res_clamp; step <= P_TD; end
              P_TD: begin num <= alu_res; step <= P_DR; end
              P_DR: begin mag <= res_clamp; step <= P_MX; end
              P_DS: begin mag <= res_clamp; step <= P_MX; end
              P_MX: begin num <= alu_res; step <= P_DX; end
              P_DX: begin
                fxm  <= res_comp;
                psat <= psat | (alu_res[127:47] != '0);
                step <= P_MY;
              end
              P_MY: begin num <= alu_res; step <= P_DY; end
              P_DY: begin
                fym   <= res_comp;
                psat  <= psat | (alu_res[127:47] != '0);
                state <= S_ACC_I;
              end
              default: state <= S_NEXT;
            endcase
          end
        end
        S_ACC_I: state <= S_ACC_J;
        S_ACC_J: state <= S_ACC_W;
        S_ACC_W: state <= S_NEXT;
        S_NEXT: begin
          // advance to the next pair, j below i
          if (j + 1'b1 == i) begin
            if (i + 1'b1 == n) begin
              k     <= '0;
              state <= S_OUT_RD;
            end else begin
              i     <= i + 1'b1;
              j     <= '0;
              state <= S_RD_I;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_RD_I;
          end
        end
        S_OUT_RD: state <= S_OUT_SHOW;
        S_OUT_SHOW: begin
          // hold the word until taken
          if (out_ready) begin
            if (k == n - 1'b1) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> !alu_busy)
    else $error("shared unit started while busy");
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> (state == S_CALC) && wait_alu)
    else $error("unexpected result from shared unit");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BODIES))
    else $error("load count beyond store depth");
  a_out_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (k < n))
    else $error("result index beyond loaded set");

endmodule
